### src/ffrp_pkg.sv
// ----------------------------------------------------------------------------
// ffrp_pkg
// Shared types and constants for the FASTA/FASTQ record parser.
// ----------------------------------------------------------------------------
package ffrp_pkg;

  // Width of the internal base and quality counters
  localparam int COUNT_BITS = 24;
  // Width of the reported base length
  localparam int LEN_BITS   = 24;

  // Output beat payload: value, is_fastq, base_length, length_mismatch, count_overflow
  localparam int PAYLOAD_BITS = 8 + 1 + LEN_BITS + 1 + 1;
  localparam int TDATA_BITS   = ((PAYLOAD_BITS + 7) / 8) * 8;
  localparam int KIND_BITS    = 3;

  // Characters that steer the parser
  localparam logic [7:0] CH_FASTA = 8'h3E;  // '>'
  localparam logic [7:0] CH_FASTQ = 8'h40;  // '@'
  localparam logic [7:0] CH_NL    = 8'h0A;  // '\n'
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_FA_HEAD  = 3'd1,
    PH_FA_BASES = 3'd2,
    PH_HALT     = 3'd3,
    PH_FQ_HEAD  = 3'd4,
    PH_FQ_BASES = 3'd5,
    PH_FQ_PLUS  = 3'd6,
    PH_FQ_QUAL  = 3'd7
  } phase_e;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_HEAD  = 3'd0,
    KIND_BASE  = 3'd1,
    KIND_QUAL  = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           value;
    logic                 is_fastq;
    logic [LEN_BITS-1:0]  base_length;
    logic                 length_mismatch;
    logic                 count_overflow;
  } result_t;

endpackage

### src/ffrp_core.sv
// ----------------------------------------------------------------------------
// ffrp_core
// Record state machine: takes one byte per beat, updates the record state
// and forms at most one tagged result for the same beat.
// ----------------------------------------------------------------------------
module ffrp_core import ffrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,     // input beat accepted this cycle
  input  logic [7:0] data_i,
  input  logic       eoi_i,
  output logic       res_vld_o,  // a result belongs to this beat
  output result_t    res_o
);

  localparam int WideBits = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
  localparam logic [LEN_BITS-1:0]   LenMax = '1;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  phase_e                phase_q, phase_d;
  logic                  fastq_q, fastq_d;
  logic [COUNT_BITS-1:0] base_cnt_q, base_cnt_d;
  logic [COUNT_BITS-1:0] qual_cnt_q, qual_cnt_d;
  logic                  ovf_q, ovf_d;

  logic                  is_end;
  logic                  is_nl;
  logic [WideBits-1:0]   base_wide;
  logic                  len_sat;

  assign is_end    = eoi_i || (data_i == CH_NUL);
  assign is_nl     = (data_i == CH_NL);
  assign base_wide = WideBits'(base_cnt_q);
  assign len_sat   = base_wide > WideBits'(LenMax);

  // Next record state
  always_comb begin
    phase_d    = phase_q;
    fastq_d    = fastq_q;
    base_cnt_d = base_cnt_q;
    qual_cnt_d = qual_cnt_q;
    ovf_d      = ovf_q;
    if (is_end) begin
      phase_d = PH_IDLE;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (data_i == CH_FASTA || data_i == CH_FASTQ) begin
            fastq_d    = (data_i == CH_FASTQ);
            base_cnt_d = '0;
            qual_cnt_d = '0;
            ovf_d      = 1'b0;
            phase_d    = (data_i == CH_FASTQ) ? PH_FQ_HEAD : PH_FA_HEAD;
          end else if (!is_nl) begin
            fastq_d = 1'b0;
            phase_d = PH_HALT;
          end
        end
        PH_FA_HEAD: begin
          if (is_nl) phase_d = PH_FA_BASES;
        end
        PH_FA_BASES: begin
          if (data_i == CH_FASTA) begin
            // next record starts on the same beat
            fastq_d    = 1'b0;
            base_cnt_d = '0;
            qual_cnt_d = '0;
            ovf_d      = 1'b0;
            phase_d    = PH_FA_HEAD;
          end else if (!is_nl) begin
            if (base_cnt_q == CntMax) ovf_d = 1'b1;
            else base_cnt_d = base_cnt_q + 1'b1;
          end
        end
        PH_HALT: begin
          phase_d = PH_HALT;
        end
        PH_FQ_HEAD: begin
          if (is_nl) phase_d = PH_FQ_BASES;
        end
        PH_FQ_BASES: begin
          if (is_nl) begin
            phase_d = PH_FQ_PLUS;
          end else if (base_cnt_q == CntMax) begin
            ovf_d = 1'b1;
          end else begin
            base_cnt_d = base_cnt_q + 1'b1;
          end
        end
        PH_FQ_PLUS: begin
          if (is_nl) phase_d = PH_FQ_QUAL;
        end
        PH_FQ_QUAL: begin
          if (is_nl) begin
            phase_d = PH_IDLE;
          end else if (qual_cnt_q == CntMax) begin
            ovf_d = 1'b1;
          end else begin
            qual_cnt_d = qual_cnt_q + 1'b1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Result for this beat
  always_comb begin
    res_vld_o             = 1'b0;
    res_o.kind            = KIND_HEAD;
    res_o.value           = data_i;
    res_o.is_fastq        = fastq_q;
    res_o.base_length     = '0;
    res_o.length_mismatch = 1'b0;
    res_o.count_overflow  = 1'b0;
    if (is_end) begin
      res_vld_o = (phase_q != PH_IDLE) && (phase_q != PH_HALT);
      res_o.kind = KIND_END;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          res_vld_o  = !is_nl && (data_i != CH_FASTA) && (data_i != CH_FASTQ);
          res_o.kind = KIND_ERROR;
        end
        PH_FA_HEAD, PH_FQ_HEAD: begin
          res_vld_o  = !is_nl;
          res_o.kind = KIND_HEAD;
        end
        PH_FA_BASES: begin
          res_vld_o  = !is_nl;
          res_o.kind = (data_i == CH_FASTA) ? KIND_END : KIND_BASE;
        end
        PH_FQ_BASES: begin
          res_vld_o  = !is_nl;
          res_o.kind = KIND_BASE;
        end
        PH_FQ_QUAL: begin
          res_vld_o  = 1'b1;
          res_o.kind = is_nl ? KIND_END : KIND_QUAL;
        end
        default: res_vld_o = 1'b0;
      endcase
    end
    // record end carries the summary, error carries nothing
    if (res_o.kind == KIND_END) begin
      res_o.value           = '0;
      res_o.base_length     = len_sat ? LenMax : base_wide[LEN_BITS-1:0];
      res_o.length_mismatch = fastq_q && (qual_cnt_q != base_cnt_q);
      res_o.count_overflow  = ovf_q || len_sat;
    end else if (res_o.kind == KIND_ERROR) begin
      res_o.value    = '0;
      res_o.is_fastq = 1'b0;
    end
    res_vld_o = res_vld_o && fire_i;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      fastq_q    <= 1'b0;
      base_cnt_q <= '0;
      qual_cnt_q <= '0;
      ovf_q      <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      fastq_q    <= fastq_d;
      base_cnt_q <= base_cnt_d;
      qual_cnt_q <= qual_cnt_d;
      ovf_q      <= ovf_d;
    end
  end

`ifndef SYNTH
  // FASTA phases never run with the FASTQ flag set
  a_fa_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FA_HEAD || phase_q == PH_FA_BASES) |-> !fastq_q)
    else $error("FASTA phase with FASTQ mode set");

  // FASTQ phases always run with the FASTQ flag set
  a_fq_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FQ_HEAD || phase_q == PH_FQ_BASES ||
     phase_q == PH_FQ_PLUS || phase_q == PH_FQ_QUAL) |-> fastq_q)
    else $error("FASTQ phase without FASTQ mode");

  // A format error only comes from the idle phase and leads to halt
  a_err_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && res_o.kind == KIND_ERROR) |=> (phase_q == PH_HALT))
    else $error("format error without halt");
`endif

endmodule

### src/ffrp_skid.sv
// ----------------------------------------------------------------------------
// ffrp_skid
// Two-entry output buffer: a result register plus a skid register, so the
// input side keeps taking beats while a result waits downstream.
// ----------------------------------------------------------------------------
module ffrp_skid import ffrp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,   // a result enters this cycle
  input  result_t push_data_i,
  output logic    ready_o,  // room for the next beat
  output logic    out_vld_o,
  input  logic    out_rdy_i,
  output result_t out_data_o
);

  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;
  logic    out_take;

  assign out_take   = out_vld_q && out_rdy_i;
  assign ready_o    = !skid_vld_q;
  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) skid_vld_q <= 1'b0;
    end else if (push_i) begin
      if (!out_vld_q || out_take) out_vld_q <= 1'b1;
      else skid_vld_q <= 1'b1;
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) out_q <= skid_q;
    end else if (push_i) begin
      if (!out_vld_q || out_take) out_q <= push_data_i;
      else skid_q <= push_data_i;
    end
  end

`ifndef SYNTH
  // The skid entry is never filled ahead of the result register
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty result register");

  // A held skid entry stays until the result register drains
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_rdy_i) |=> skid_vld_q)
    else $error("skid entry lost during stall");

  // A stalled output beat keeps its valid and its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_rdy_i) |=> (out_vld_q && $stable(out_q)))
    else $error("output beat changed during stall");
`endif

endmodule

### src/fasta_fastq_record_parser.sv
// ----------------------------------------------------------------------------
// fasta_fastq_record_parser
// Splits a text byte stream into FASTA or FASTQ record beats.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one text byte per beat in tdata; tlast marks the
// end of input, and a zero byte counts as end of input as well.
// Output channel (m_axis): tuser gives the kind (header byte, base, quality,
// record end, format error); tdata carries the byte, the record format and,
// on a record end, saturated base length, length mismatch and overflow.
// Newlines, record-start markers and the FASTQ plus line give no beat of
// their own; a '>' after FASTA bases and the newline closing a quality line
// carry the record end of the record they close.
// Throughput: one input byte per cycle while the skid register is empty; the
// next record state is combinational, so no byte waits on the one before it.
// A result reaches m_axis from the result register, via the skid register if full.
// Stall: results queue in a result register and a skid register; tready
// drops only while both hold a beat, and nothing is lost or repeated.
// Reset: the parser waits for a record start, counters clear and the output
// buffer empties. After a format error, bytes are dropped until end of input.
// ----------------------------------------------------------------------------
module fasta_fastq_record_parser import ffrp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data
  input  logic                  s_axis_tlast,   // end_of_input
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_BITS-1:0] m_axis_tdata,   // value, is_fastq, base_length,
                                                // length_mismatch, count_overflow, pad
  output logic [KIND_BITS-1:0]  m_axis_tuser    // kind
);

  logic    fire;
  logic    res_vld;
  result_t res;
  result_t out;

  assign fire = s_axis_tvalid && s_axis_tready;

  // Record state and per-beat result
  ffrp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .data_i    (s_axis_tdata),
    .eoi_i     (s_axis_tlast),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Output buffering
  ffrp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .ready_o     (s_axis_tready),
    .out_vld_o   (m_axis_tvalid),
    .out_rdy_i   (m_axis_tready),
    .out_data_o  (out)
  );

  // Pack the output beat, first field lowest
  assign m_axis_tdata = {{(TDATA_BITS - PAYLOAD_BITS){1'b0}},
                         out.count_overflow, out.length_mismatch,
                         out.base_length, out.is_fastq, out.value};
  assign m_axis_tuser = out.kind;

endmodule
